// ===== design/cspid_pkg.sv =====
// ----------------------------------------------------------------------------
// cspid_pkg
// Shared types, constants and helpers for the callsign packer.
// ----------------------------------------------------------------------------
package cspid_pkg;

  localparam int unsigned SymbolW = 8;
  localparam int unsigned IdW     = 28;
  localparam int unsigned PrefixW = 13;
  localparam int unsigned SuffixW = 15;
  localparam int unsigned CountW  = 2;
  localparam int unsigned LetterW = 5;

  localparam logic [4:0]  BaseLetters = 5'd27;
  localparam logic [3:0]  BaseRegion  = 4'd10;
  localparam logic [14:0] SuffixSpan  = 15'd19683;

  localparam logic [SymbolW-1:0] ChLowA  = 8'h61;
  localparam logic [SymbolW-1:0] ChLowZ  = 8'h7A;
  localparam logic [SymbolW-1:0] ChUpA   = 8'h41;
  localparam logic [SymbolW-1:0] ChUpZ   = 8'h5A;
  localparam logic [SymbolW-1:0] ChZero  = 8'h30;
  localparam logic [SymbolW-1:0] ChNine  = 8'h39;

  localparam logic [CountW-1:0] MaxPrefixLetters = 2'd2;
  localparam logic [CountW-1:0] MaxSuffixLetters = 2'd3;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_SUFFIX = 2'd1,
    PH_ERROR  = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [CountW-1:0]   letter_count;
    logic [PrefixW-1:0]  prefix_value;
    logic [SuffixW-1:0]  suffix_value;
  } cspid_state_t;

  localparam cspid_state_t StateReset = '{
    phase:        PH_PREFIX,
    letter_count: '0,
    prefix_value: '0,
    suffix_value: '0
  };

  // 1..26 for a letter of either case, 0 otherwise
  function automatic logic [LetterW-1:0] letter_code(input logic [SymbolW-1:0] ch);
    logic [SymbolW-1:0] diff;
    diff = '0;
    if (ch >= ChLowA && ch <= ChLowZ) begin
      diff = ch - ChLowA + 8'd1;
    end else if (ch >= ChUpA && ch <= ChUpZ) begin
      diff = ch - ChUpA + 8'd1;
    end
    return diff[LetterW-1:0];
  endfunction

endpackage

// ===== design/cspid_step.sv =====
// ----------------------------------------------------------------------------
// cspid_step
// Next-state logic: absorbs one character into the callsign parse state.
// ----------------------------------------------------------------------------
module cspid_step import cspid_pkg::*; (
  input  cspid_state_t        state_i,
  input  logic [SymbolW-1:0]  symbol_i,
  output cspid_state_t        state_o
);

  logic [LetterW-1:0] lv;
  logic               is_digit;
  logic [3:0]         digit;
  logic [17:0]        pre_letter;
  logic [16:0]        pre_region;
  logic [19:0]        suf_letter;
  logic [SymbolW-1:0] digit_full;

  assign lv         = letter_code(symbol_i);
  assign is_digit   = (symbol_i >= ChZero) && (symbol_i <= ChNine);
  assign digit_full = symbol_i - ChZero;
  assign digit      = digit_full[3:0];
  assign pre_letter = 18'(state_i.prefix_value * BaseLetters) + 18'(lv);
  assign pre_region = 17'(state_i.prefix_value * BaseRegion) + 17'(digit);
  assign suf_letter = 20'(state_i.suffix_value * BaseLetters) + 20'(lv);

  always_comb begin
    state_o = state_i;
    unique case (state_i.phase)
      PH_PREFIX: begin
        if (lv != '0) begin
          if (state_i.letter_count < MaxPrefixLetters) begin
            state_o.prefix_value = pre_letter[PrefixW-1:0];
            state_o.letter_count = state_i.letter_count + 2'd1;
          end else begin
            state_o.phase = PH_ERROR;
          end
        end else if (is_digit) begin
          if (state_i.letter_count == '0) begin
            state_o.phase = PH_ERROR;
          end else begin
            state_o.prefix_value = pre_region[PrefixW-1:0];
            state_o.phase        = PH_SUFFIX;
            state_o.letter_count = '0;
          end
        end else begin
          state_o.phase = PH_ERROR;
        end
      end
      PH_SUFFIX: begin
        if (lv != '0 && state_i.letter_count < MaxSuffixLetters) begin
          state_o.suffix_value = suf_letter[SuffixW-1:0];
          state_o.letter_count = state_i.letter_count + 2'd1;
        end else begin
          state_o.phase = PH_ERROR;
        end
      end
      default: begin
        state_o.phase = PH_ERROR;
      end
    endcase
  end

endmodule

// ===== design/callsign_to_packed_id.sv =====
// ----------------------------------------------------------------------------
// callsign_to_packed_id
// Packs a callsign, streamed one character per word, into a 28-bit id.
// ----------------------------------------------------------------------------
// One character is taken per cycle, except while a final character waits in
// the input register for the packed stage to free up. The character is
// registered and absorbed into the parse state, and on the final character
// the prefix and suffix are registered and then combined (prefix * 19683 +
// suffix) into the output register. The input and a pending result are
// buffered separately, so characters keep flowing while a result waits to be taken.
module callsign_to_packed_id import cspid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SymbolW-1:0] symbol_i,
  input  logic               last_symbol_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IdW-1:0]     call_id_o,
  output logic               valid_res_o
);

  // input stage
  logic               s1_v_q;
  logic [SymbolW-1:0] s1_sym_q;
  logic               s1_last_q;
  // packed stage
  logic               s2_v_q;
  logic               s2_ok_q;
  logic [PrefixW-1:0] s2_pre_q;
  logic [SuffixW-1:0] s2_suf_q;
  // output stage
  logic               out_v_q;
  logic [IdW-1:0]     out_id_q;
  logic               out_ok_q;

  cspid_state_t state_q, state_d, state_nx;

  logic o_free, s2_free, s1_adv, in_take, s2_load, s2_adv;
  logic ok_nx;
  logic [IdW+1:0] id_full;

  cspid_step u_step (
    .state_i  (state_q),
    .symbol_i (s1_sym_q),
    .state_o  (state_nx)
  );

  assign o_free     = !out_v_q || out_ready_i;
  assign s2_free    = !s2_v_q || o_free;
  assign s1_adv     = s1_v_q && (!s1_last_q || s2_free);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign in_take    = in_valid_i && in_ready_o;
  assign s2_load    = s1_adv && s1_last_q;
  assign s2_adv     = s2_v_q && o_free;

  assign ok_nx   = (state_nx.phase == PH_SUFFIX) && (state_nx.letter_count != '0);
  assign state_d = s2_load ? StateReset : state_nx;
  assign id_full = 30'(s2_pre_q * SuffixSpan) + 30'(s2_suf_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= StateReset;
    end else begin
      if (in_take) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s2_load) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (s1_adv) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_sym_q  <= symbol_i;
      s1_last_q <= last_symbol_i;
    end
    if (s2_load) begin
      s2_ok_q  <= ok_nx;
      s2_pre_q <= state_nx.prefix_value;
      s2_suf_q <= state_nx.suffix_value;
    end
    if (s2_adv) begin
      out_ok_q <= s2_ok_q;
      out_id_q <= s2_ok_q ? id_full[IdW-1:0] : '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign call_id_o   = out_id_q;
  assign valid_res_o = out_ok_q;

endmodule

// ===== design/cspid_checker.sv =====
// ----------------------------------------------------------------------------
// cspid_checker
// Port-level checks on the callsign packer's result channel.
// ----------------------------------------------------------------------------
module cspid_checker import cspid_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [IdW-1:0]     call_id_o,
  input logic               valid_res_o
);

  localparam logic [IdW-1:0] MaxId = 28'd143489069;

  // rejected callsign carries a zero id
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> call_id_o == '0)
    else $error("format error word with non-zero id");

  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> call_id_o <= MaxId)
    else $error("id out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(call_id_o) && $stable(valid_res_o))
    else $error("stalled result word changed");

  // with the output free, input buffering must never block
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && !$past(in_valid_i) |-> in_ready_o)
    else $error("input blocked while pipeline empty");

endmodule

bind callsign_to_packed_id cspid_checker u_cspid_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .call_id_o   (call_id_o),
  .valid_res_o (valid_res_o)
);

// ===== sim/callsign_to_packed_id_tb.sv =====
// ----------------------------------------------------------------------------
// callsign_to_packed_id_tb
// Self-checking bench for the callsign packer.
// ----------------------------------------------------------------------------
// A queue of character words feeds a valid/ready driver. Each accepted word
// is run through a local parse model, and every final character queues the
// expected id. A monitor compares each returned word with the oldest
// expectation. There is a short directed run, then random callsigns, mostly
// well formed with some broken or noisy ones. This random traffic runs under
// several idle and stall mixes, and one long receiver hold-off that backs up
// the input.
module callsign_to_packed_id_tb;
  import cspid_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned PhaseChars    = 385;
  localparam int unsigned PressureChars = 400;

  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               last;
  } char_word_t;

  typedef struct packed {
    logic [IdW-1:0] call_id;
    logic           valid_res;
  } id_word_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [SymbolW-1:0] symbol_i      = '0;
  logic               last_symbol_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [IdW-1:0]     call_id_o;
  logic               valid_res_o;

  char_word_t   pending_chars[$];
  id_word_t     expected_ids[$];
  cspid_state_t parse_state = StateReset;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned holds_started  = 0;
  int unsigned hold_left      = 0;
  int unsigned chars_counted  = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;
  logic        in_taken       = 1'b0;

  callsign_to_packed_id dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .symbol_i     (symbol_i),
    .last_symbol_i(last_symbol_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .call_id_o    (call_id_o),
    .valid_res_o  (valid_res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic cspid_state_t absorb_char(cspid_state_t s, logic [SymbolW-1:0] ch);
    logic [7:0]   lv;
    int unsigned  acc;
    cspid_state_t n;
    n  = s;
    lv = '0;
    if (ch >= ChLowA && ch <= ChLowZ) begin
      lv = ch - ChLowA + 8'd1;
    end else if (ch >= ChUpA && ch <= ChUpZ) begin
      lv = ch - ChUpA + 8'd1;
    end
    case (s.phase)
      PH_PREFIX: begin
        if (lv != 0) begin
          if (s.letter_count < MaxPrefixLetters) begin
            acc = 32'(s.prefix_value) * 27 + 32'(lv);
            n.prefix_value = acc[PrefixW-1:0];
            n.letter_count = s.letter_count + 2'd1;
          end else begin
            n.phase = PH_ERROR;
          end
        end else if (ch >= ChZero && ch <= ChNine) begin
          if (s.letter_count == 0) begin
            n.phase = PH_ERROR;
          end else begin
            acc = 32'(s.prefix_value) * 10 + 32'(ch - ChZero);
            n.prefix_value = acc[PrefixW-1:0];
            n.phase        = PH_SUFFIX;
            n.letter_count = '0;
          end
        end else begin
          n.phase = PH_ERROR;
        end
      end
      PH_SUFFIX: begin
        if (lv != 0 && s.letter_count < MaxSuffixLetters) begin
          acc = 32'(s.suffix_value) * 27 + 32'(lv);
          n.suffix_value = acc[SuffixW-1:0];
          n.letter_count = s.letter_count + 2'd1;
        end else begin
          n.phase = PH_ERROR;
        end
      end
      default: begin
        n.phase = PH_ERROR;
      end
    endcase
    return n;
  endfunction

  function automatic id_word_t packed_id(cspid_state_t s);
    id_word_t    r;
    int unsigned full;
    r = '0;
    if (s.phase == PH_SUFFIX && s.letter_count != 0) begin
      full        = 32'(s.prefix_value) * 32'(SuffixSpan) + 32'(s.suffix_value);
      r.call_id   = full[IdW-1:0];
      r.valid_res = 1'b1;
    end
    return r;
  endfunction

  task automatic push_char(input logic [SymbolW-1:0] sym, input logic last);
    char_word_t w;
    w.symbol = sym;
    w.last   = last;
    chars_counted++;
    pending_chars.push_back(w);
  endtask

  task automatic push_call(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [SymbolW-1:0] random_letter();
    return ($urandom_range(1) ? ChUpA : ChLowA) + 8'($urandom_range(25));
  endfunction

  function automatic logic [SymbolW-1:0] noise_byte();
    logic [SymbolW-1:0] edges[8];
    edges = '{8'h00, 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF};
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return edges[$urandom_range(7)];
  endfunction

  task automatic push_random_call();
    int unsigned        n_pre;
    int unsigned        n_suf;
    int unsigned        len;
    int unsigned        r;
    logic [SymbolW-1:0] sym;
    if ($urandom_range(99) < 75) begin
      n_pre = $urandom_range(1, 2);
      n_suf = $urandom_range(1, 3);
      for (int i = 0; i < n_pre; i++) push_char(random_letter(), 1'b0);
      push_char(ChZero + 8'($urandom_range(9)), 1'b0);
      for (int i = 0; i < n_suf; i++) push_char(random_letter(), i == n_suf - 1);
    end else begin
      len = $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(9);
        if (r < 5) sym = random_letter();
        else if (r < 7) sym = ChZero + 8'($urandom_range(9));
        else sym = noise_byte();
        push_char(sym, i == len - 1);
      end
    end
  endtask

  task automatic run_random(input int unsigned n_chars);
    chars_counted = 0;
    while (chars_counted < n_chars) push_random_call();
  endtask

  task automatic drain();
    while (pending_chars.size() != 0 || in_valid_i || expected_ids.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input id_word_t exp_w);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("mismatch (%s) at %0t: expected id %0d valid %0b, got id %0d valid %0b",
               what, $realtime, exp_w.call_id, exp_w.valid_res, call_id_o, valid_res_o);
    end
  endtask

  // sender
  always @(negedge clk_i) begin : drive_b
    char_word_t w;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_chars.pop_front();
        in_valid_i    <= 1'b1;
        symbol_i      <= w.symbol;
        last_symbol_i <= w.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with the occasional long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (holds_started < hold_reqs) begin
      holds_started <= holds_started + 1;
      hold_left     <= HoldOffCycles;
      out_ready_i   <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check returned words first, then model the accepted character
  always @(posedge clk_i) begin : check_b
    id_word_t exp_w;
    logic     in_acc;
    logic     out_acc;
    in_acc  = rst_ni && in_valid_i && in_ready_o;
    out_acc = rst_ni && out_valid_o && out_ready_i;
    in_taken <= in_acc;
    if (out_acc) begin
      if (expected_ids.size() == 0) begin
        note_mismatch("unexpected word", '0);
      end else begin
        exp_w = expected_ids.pop_front();
        if (call_id_o !== exp_w.call_id) note_mismatch("call_id", exp_w);
        else if (valid_res_o !== exp_w.valid_res) note_mismatch("valid_res", exp_w);
      end
    end
    if (in_acc) begin
      parse_state = absorb_char(parse_state, symbol_i);
      if (last_symbol_i) begin
        expected_ids.push_back(packed_id(parse_state));
        parse_state = StateReset;
      end
    end
    if (!rst_ni || in_acc || out_acc) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and format errors
    push_call("A0A");
    push_call("zz9zzz");
    push_char(8'h00, 1'b1);
    push_call("9K");
    push_call("KWX");
    push_call("K12");
    push_call("A0AAAA");
    push_call("K6");
    drain();

    run_random(PhaseChars);
    drain();

    send_idle_pct = 85;
    run_random(PhaseChars);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 85;
    run_random(PhaseChars);
    drain();

    send_idle_pct  = 34;
    recv_stall_pct = 34;
    run_random(PhaseChars);
    drain();

    // back-pressure: receiver parked while the sender keeps going
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs      = hold_reqs + 1;
    run_random(PressureChars);
    drain();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
